FILE: src/obst_pkg.sv
// Shared types and constants for the optimal search tree cost table.
// Request and result payloads, sequencer states and shared-unit controls.
// No dependencies.
package obst_pkg;

    localparam int MAX_KEYS_DEF    = 8;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int COST_OUT_BITS   = 22;
    localparam logic [COST_OUT_BITS-1:0] COST_MAX = '1;

    typedef struct packed {
        logic [15:0] key_value;
        logic [15:0] weight;
        logic        last_key;
    } t_req;

    typedef struct packed {
        logic [3:0]               range_start;
        logic [3:0]               range_end;
        logic [COST_OUT_BITS-1:0] cost;
        logic [3:0]               root_index;
        logic [15:0]              root_key;
        logic                     overflow;
        logic                     last;
    } t_res;

    typedef struct packed {
        logic clear;
        logic step;
    } t_unit_ctl;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_START = 6'b000100,
        S_READ  = 6'b001000,
        S_ACC   = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

endpackage

FILE: src/obst_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module obst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

FILE: src/obst_unit.sv
// Shared add-compare unit: running minimum over candidate roots and range weight sum.
// Depends on obst_pkg.
module obst_unit import obst_pkg::*; #(
    parameter int CW = 24,
    parameter int IW = 4,
    parameter int WB = 16
) (
    input  logic          i_clk,
    input  t_unit_ctl     i_ctl,
    input  logic [IW-1:0] i_k,
    input  logic [CW-1:0] i_cost_a,
    input  logic [CW-1:0] i_cost_b,
    input  logic [WB-1:0] i_weight,
    output logic [CW-1:0] o_total,
    output logic [IW-1:0] o_root
);

    localparam int WSW = WB + IW;

    logic [CW-1:0]  r_best;
    logic [IW-1:0]  r_root;
    logic [WSW-1:0] r_wsum;
    logic           r_first;
    logic [CW-1:0]  cand;

    assign cand = i_cost_a + i_cost_b;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_first <= 1'b1;
            r_wsum  <= '0;
        end else if (i_ctl.step) begin
            if (r_first || cand < r_best) begin
                r_best <= cand;
                r_root <= i_k;
            end
            r_first <= 1'b0;
            r_wsum  <= r_wsum + WSW'(i_weight);
        end
    end

    assign o_total = r_best + CW'(r_wsum);
    assign o_root  = r_root;

endmodule

FILE: src/optimal_bst_cost_table.sv
// Optimal binary search tree cost table, successful searches only.
// Keys load one per cycle; the last-marked key starts the fill, input stalls meanwhile.
// Fill of n keys: the diagonal is cleared first, then the ranges in order of width,
// each with a cost RAM read and one shared add-compare per candidate root; results are
// sent when the output is free. Synchronous active-low reset returns to key loading.
module optimal_bst_cost_table import obst_pkg::*; #(
    parameter int MAX_KEYS    = MAX_KEYS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int SIDE = MAX_KEYS + 1;
    localparam int IW   = $clog2(SIDE);
    localparam int KIW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int WB   = WEIGHT_BITS;
    localparam int CW   = WB + 2 * IW;
    localparam int AW   = $clog2(SIDE * SIDE);
    localparam int SW   = (CW > COST_OUT_BITS) ? CW : COST_OUT_BITS;
    localparam logic [AW-1:0] SIDE_A = AW'(SIDE);

    t_state        r_state, n_state;
    logic [15:0]   r_keys    [MAX_KEYS];
    logic [WB-1:0] r_weights [MAX_KEYS];
    logic [IW-1:0] r_count, r_n, r_i, r_j, r_k, r_width;
    logic          r_drop;
    logic          r_res_valid;
    t_res          r_res;

    logic          req_fire, full, w_fire, range_done;
    logic [IW-1:0] count_inc, k_m1, root_m1;
    logic [AW-1:0] waddr;
    logic [CW-1:0] wdata, rd_a, rd_b, total;
    logic [IW-1:0] root;
    logic          we;
    t_unit_ctl     ctl;
    logic [SW-1:0] total_ext;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] a, input logic [IW-1:0] b);
        addr_of = AW'(a) * SIDE_A + AW'(b);
    endfunction

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign full        = (r_count == IW'(MAX_KEYS));
    assign count_inc   = r_count + IW'(1);
    assign w_fire      = (r_state == S_WRITE) && (!r_res_valid || i_res_ready);
    assign range_done  = (r_j == r_n);
    assign k_m1        = r_k - IW'(1);
    assign root_m1     = root - IW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire && i_req.last_key) n_state = S_INIT;
            end
            S_INIT: begin
                if (r_i == r_n) n_state = S_START;
            end
            S_START: n_state = S_READ;
            S_READ:  n_state = S_ACC;
            S_ACC: begin
                n_state = (r_k == r_j) ? S_WRITE : S_READ;
            end
            S_WRITE: begin
                if (w_fire) n_state = (range_done && r_width == r_n) ? S_IDLE : S_START;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        if (full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_count <= count_inc;
                        end
                        r_n <= full ? r_count : count_inc;
                        r_i <= '0;
                    end
                end
                S_INIT: begin
                    if (r_i == r_n) begin
                        r_i     <= '0;
                        r_width <= IW'(1);
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                S_START: begin
                    r_j <= r_i + r_width;
                    r_k <= r_i + IW'(1);
                end
                S_READ: ;
                S_ACC: begin
                    if (r_k != r_j) r_k <= r_k + IW'(1);
                end
                S_WRITE: begin
                    if (w_fire) begin
                        if (range_done) begin
                            r_i     <= '0;
                            r_width <= r_width + IW'(1);
                            if (r_width == r_n) begin
                                r_count <= '0;
                                r_drop  <= 1'b0;
                            end
                        end else begin
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire && !full) begin
            r_keys[r_count[KIW-1:0]]    <= i_req.key_value;
            r_weights[r_count[KIW-1:0]] <= WB'(i_req.weight);
        end
    end

    assign we    = (r_state == S_INIT) || w_fire;
    assign waddr = (r_state == S_INIT) ? addr_of(r_i, r_i) : addr_of(r_i, r_j);
    assign wdata = (r_state == S_INIT) ? '0 : total;

    obst_ram #(
        .WIDTH (CW),
        .DEPTH (SIDE * SIDE)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (addr_of(r_i, k_m1)),
        .i_raddr_b (addr_of(r_k, r_j)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign ctl.clear = (r_state == S_START);
    assign ctl.step  = (r_state == S_ACC);

    obst_unit #(
        .CW (CW),
        .IW (IW),
        .WB (WB)
    ) u_unit (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_k      (r_k),
        .i_cost_a (rd_a),
        .i_cost_b (rd_b),
        .i_weight (r_weights[k_m1[KIW-1:0]]),
        .o_total  (total),
        .o_root   (root)
    );

    assign total_ext = SW'(total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_fire) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.range_start <= 4'(r_i);
            r_res.range_end   <= 4'(r_j);
            r_res.cost        <= (total_ext > SW'(COST_MAX)) ? COST_MAX
                                                             : total_ext[COST_OUT_BITS-1:0];
            r_res.root_index  <= 4'(root);
            r_res.root_key    <= r_keys[root_m1[KIW-1:0]];
            r_res.overflow    <= r_drop;
            r_res.last        <= (r_i == '0) && range_done;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_acc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ($past(r_state) == S_READ))
        else $error("accumulate step without a preceding read");

    a_root_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_ACC) |-> (r_k > r_i && r_k <= r_j))
        else $error("candidate root outside its range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= IW'(MAX_KEYS)))
        else $error("key count beyond capacity");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_i == '0 && range_done) |=> (r_state == S_IDLE && r_count == '0 && !r_drop))
        else $error("run did not close after the full-range result");

endmodule

FILE: tb/sv/tb_optimal_bst_cost_table.sv
// Self-checking testbench for optimal_bst_cost_table: drives key requests, predicts every range result.
// Directed table first, then random runs under three idling phases on both handshakes.
// Depends on obst_pkg and the optimal_bst_cost_table RTL.
module tb_optimal_bst_cost_table;
    import obst_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 105;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] weight;
        logic        last_key;
        logic        typed;
        t_res        want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req = '0;
    logic o_res_valid;
    logic i_res_ready = 1'b0;
    t_res o_res;

    logic [15:0] held_keys [MAX_KEYS_DEF];
    logic [15:0] held_weights [MAX_KEYS_DEF];
    int          held_count = 0;
    logic        keys_dropped = 1'b0;

    t_res pending_costs [$];
    int   send_idle_pct = 25;
    int   recv_idle_pct = 68;
    int   cycle_count = 0;
    int   error_count = 0;
    int   requests_sent = 0;
    int   runs_done = 0;
    int   overflow_runs = 0;
    int   spans_checked = 0;
    int   random_items = 0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{16'h0000, 16'h0000, 1'b1, 1'b1, '{4'd0, 4'd1, 22'd0, 4'd1, 16'h0000, 1'b0, 1'b1}},
        '{16'hffff, 16'hffff, 1'b1, 1'b1, '{4'd0, 4'd1, 22'd65535, 4'd1, 16'hffff, 1'b0, 1'b1}},
        '{16'h0010, 16'h0001, 1'b0, 1'b0, '0},
        '{16'h0020, 16'hffff, 1'b0, 1'b0, '0},
        '{16'h0030, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0040, 16'h0300, 1'b0, 1'b0, '0},
        '{16'h0050, 16'h0007, 1'b0, 1'b0, '0},
        '{16'h0060, 16'h8000, 1'b0, 1'b0, '0},
        '{16'h0070, 16'h0040, 1'b0, 1'b0, '0},
        '{16'h0080, 16'h0002, 1'b0, 1'b0, '0},
        '{16'h0090, 16'h1234, 1'b0, 1'b0, '0},
        '{16'h00a0, 16'h0055, 1'b1, 1'b0, '0},
        '{16'h0100, 16'h0000, 1'b0, 1'b0, '0},
        '{16'h0200, 16'h0000, 1'b1, 1'b0, '0},
        '{16'h0300, 16'h0005, 1'b0, 1'b0, '0},
        '{16'h0400, 16'h0005, 1'b0, 1'b0, '0},
        '{16'h0500, 16'h0005, 1'b1, 1'b0, '0},
        '{16'h0001, 16'hffff, 1'b0, 1'b0, '0},
        '{16'h2000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'h4000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'h6000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'h8000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'ha000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'hc000, 16'hffff, 1'b0, 1'b0, '0},
        '{16'hffff, 16'hffff, 1'b1, 1'b0, '0}
    };

    optimal_bst_cost_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void solve_tree_costs(ref t_res spans[$]);
        longint unsigned cost [0:MAX_KEYS_DEF][0:MAX_KEYS_DEF];
        longint unsigned span_weight;
        longint unsigned best;
        longint unsigned cand;
        int              best_root;
        int              j;
        t_res            r;
        for (int i = 0; i <= held_count; i++) cost[i][i] = 0;
        for (int width = 1; width <= held_count; width++) begin
            for (int i = 0; i + width <= held_count; i++) begin
                j = i + width;
                span_weight = 0;
                for (int x = i + 1; x <= j; x++) span_weight += held_weights[x-1];
                best = 0;
                best_root = i + 1;
                for (int k = i + 1; k <= j; k++) begin
                    cand = cost[i][k-1] + cost[k][j] + span_weight;
                    if (k == i + 1 || cand < best) begin
                        best = cand;
                        best_root = k;
                    end
                end
                cost[i][j] = best;
                r.range_start = 4'(i);
                r.range_end   = 4'(j);
                r.cost        = (best > longint'(COST_MAX)) ? COST_MAX : 22'(best);
                r.root_index  = 4'(best_root);
                r.root_key    = held_keys[(best_root - 1) % MAX_KEYS_DEF];
                r.overflow    = keys_dropped;
                r.last        = (i == 0 && j == held_count);
                spans.push_back(r);
            end
        end
    endfunction

    function automatic void take_key(input t_req r, ref t_res spans[$]);
        if (held_count < MAX_KEYS_DEF) begin
            held_keys[held_count]    = r.key_value;
            held_weights[held_count] = r.weight;
            held_count++;
        end else begin
            keys_dropped = 1'b1;
        end
        if (r.last_key) begin
            solve_tree_costs(spans);
            runs_done++;
            if (keys_dropped) overflow_runs++;
            held_count = 0;
            keys_dropped = 1'b0;
        end
    endfunction

    task automatic send_request(input t_req r, input logic typed, input t_res want);
        t_res spans [$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_req_ready);
        requests_sent++;
        take_key(r, spans);
        if (typed && r.last_key) begin
            pending_costs.push_back(want);
        end else begin
            foreach (spans[s]) pending_costs.push_back(spans[s]);
        end
    endtask

    task automatic play_random_run();
        int          n;
        int          mode;
        logic [15:0] k;
        logic [15:0] shared_w;
        t_req        r;
        n = ($urandom_range(5) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        mode = $urandom_range(3);
        k = 16'($urandom_range(65535));
        shared_w = 16'($urandom_range(65535));
        for (int x = 0; x < n; x++) begin
            r.key_value = k;
            case (mode)
                0: r.weight = 16'($urandom_range(65535));
                1: r.weight = 16'($urandom_range(15));
                2: r.weight = shared_w;
                default: begin
                    case ($urandom_range(2))
                        0: r.weight = 16'hffff;
                        1: r.weight = 16'h0000;
                        default: r.weight = 16'($urandom_range(65535));
                    endcase
                end
            endcase
            r.last_key = (x == n - 1);
            send_request(r, 1'b0, '0);
            random_items++;
            k = k + 16'($urandom_range(1, 8191));
        end
    endtask

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_span(t_res got);
        t_res want;
        if (pending_costs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
        end else begin
            want = pending_costs.pop_front();
            spans_checked++;
            compare_field("range_start", want.range_start, got.range_start);
            compare_field("range_end", want.range_end, got.range_end);
            compare_field("cost", want.cost, got.cost);
            compare_field("root_index", want.root_index, got.root_index);
            compare_field("root_key", want.root_key, got.root_key);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("last", want.last, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) check_span(o_res);
            i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     pending_costs.size());
            $display("FAIL optimal_bst_cost_table");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_request('{directed_rows[row].key, directed_rows[row].weight,
                           directed_rows[row].last_key},
                         directed_rows[row].typed, directed_rows[row].want);
        end
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end else if (random_items >= RANDOM_ITEMS / 3) begin
                send_idle_pct <= 68;
                recv_idle_pct <= 25;
            end
            play_random_run();
        end
        i_req_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d key requests in %0d runs, %0d of them with dropped keys.",
                 requests_sent, runs_done, overflow_runs);
        $display("Checked %0d range results, %0d field mismatches.", spans_checked,
                 error_count);
        if (error_count == 0) begin
            $display("PASS optimal_bst_cost_table");
        end else begin
            $display("FAIL optimal_bst_cost_table");
        end
        $finish;
    end

endmodule
